// ----- rtl/qee_pkg.sv -----
// Package for the QUBO energy engine: operation codes, controller states
// and the command and status structures. No dependencies.
`timescale 1ns / 1ps
package qee_pkg;

  localparam int SITES_DEF         = 16;
  localparam int COUPLING_BITS_DEF = 16;

  typedef enum logic [2:0] {
    OP_WRITE  = 3'd0,
    OP_LOAD   = 3'd1,
    OP_FLIP   = 3'd2,
    OP_DELTA  = 3'd3,
    OP_ENERGY = 3'd4,
    OP_SEARCH = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TAIL,
    ST_FIN,
    ST_SUPD,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic accept;
    logic scan;
    logic tail;
    logic fin;
    logic supd;
  } cmd_t;

  typedef struct packed {
    logic start_scan;
    logic scan_last;
    logic is_search;
    logic search_last;
  } status_t;

endpackage

// ----- rtl/qee_in_if.sv -----
// Input channel of the QUBO energy engine: valid, ready and one operation.
// Depends on nothing.
`timescale 1ns / 1ps
interface qee_in_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  op;
  logic        [3:0]  row;
  logic        [3:0]  col;
  logic signed [15:0] coupling;
  logic        [15:0] spins_in;

  modport source (output valid, op, row, col, coupling, spins_in, input ready);
  modport sink   (input valid, op, row, col, coupling, spins_in, output ready);
endinterface

// ----- rtl/qee_out_if.sv -----
// Result channel of the QUBO energy engine: valid, ready and one result.
// Depends on nothing.
`timescale 1ns / 1ps
interface qee_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] energy;
  logic        [15:0] spins_out;
  logic               error;

  modport source (output valid, energy, spins_out, error, input ready);
  modport sink   (input valid, energy, spins_out, error, output ready);
endinterface

// ----- rtl/qee_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
module qee_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 136
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/qee_ctrl.sv -----
// Controller state machine of the QUBO energy engine.
// Depends on qee_pkg for the state, command and status types.
`timescale 1ns / 1ps
module qee_ctrl import qee_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t sts,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.start_scan ? ST_SCAN : ST_RESULT;
        end
      end
      ST_SCAN: begin
        if (sts.scan_last) begin
          state_nxt = ST_TAIL;
        end
      end
      ST_TAIL:   state_nxt = sts.is_search ? ST_SUPD : ST_FIN;
      ST_FIN:    state_nxt = ST_RESULT;
      ST_SUPD:   state_nxt = sts.search_last ? ST_RESULT : ST_SCAN;
      ST_RESULT: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_SCAN:   cmd.scan  = 1'b1;
      ST_TAIL:   cmd.tail  = 1'b1;
      ST_FIN:    cmd.fin   = 1'b1;
      ST_SUPD:   cmd.supd  = 1'b1;
      ST_RESULT: out_valid = 1'b1;
      default: ;
    endcase
  end

  a_excl: assert property (@(posedge clk) disable iff (!rst_n) !(out_valid && in_ready))
    else $error("ready and result valid at once");
  a_tail: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_TAIL |=> (state_r == ST_FIN || state_r == ST_SUPD))
    else $error("scan tail not followed by finish or search update");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESULT && !out_ready) |=> state_r == ST_RESULT)
    else $error("result dropped before it was taken");

endmodule

// ----- rtl/qee_datapath.sv -----
// Datapath of the QUBO energy engine: coupling store, spin vector,
// accumulator and search registers. Depends on qee_pkg and qee_ram.
`timescale 1ns / 1ps
module qee_datapath import qee_pkg::*; #(
  parameter int SITES         = SITES_DEF,
  parameter int COUPLING_BITS = COUPLING_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output status_t            sts,
  input  logic        [2:0]  in_op,
  input  logic        [3:0]  in_row,
  input  logic        [3:0]  in_col,
  input  logic signed [15:0] in_coupling,
  input  logic        [15:0] in_spins_in,
  output logic signed [31:0] res_energy,
  output logic        [15:0] res_spins,
  output logic               res_error
);

  localparam int IW    = $clog2(SITES);
  localparam int DEPTH = SITES * (SITES + 1) / 2;
  localparam int AW    = $clog2(DEPTH);
  localparam int ACC_W = COUPLING_BITS + $clog2(DEPTH) + 2;
  localparam int SW    = IW + 5;
  localparam int CB    = COUPLING_BITS;
  localparam logic signed [33:0] C_HI = 34'((64'sd1 <<< (CB - 1)) - 64'sd1);
  localparam logic signed [33:0] C_LO = -C_HI - 34'sd1;
  localparam logic signed [ACC_W+32:0] E_HI = (ACC_W+33)'(64'sd2147483647);
  localparam logic signed [ACC_W+32:0] E_LO = -E_HI - (ACC_W+33)'(1);

  function automatic logic [AW-1:0] tri_base(input logic [IW-1:0] r);
    logic [2*IW+1:0] a;
    logic [2*IW+1:0] p;
    a = (2*IW+2)'(r);
    p = a * (a + (2*IW+2)'(1));
    return AW'(p >> 1);
  endfunction

  function automatic logic [IW-1:0] ctz(input logic [SITES-1:0] v);
    logic [IW-1:0] r;
    r = '0;
    for (int n = SITES - 1; n >= 0; n--) begin
      if (v[n]) begin
        r = IW'(n);
      end
    end
    return r;
  endfunction

  function automatic logic [15:0] low16(input logic [SITES-1:0] v);
    logic [SITES+15:0] t;
    t = (SITES+16)'(v);
    return t[15:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W+32:0] x;
    x = (ACC_W+33)'(v);
    if (x > E_HI) begin
      return 32'sh7fffffff;
    end else if (x < E_LO) begin
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

  logic        [SW-1:0]       row_x, col_x;
  logic                       row_ok, col_ok, wr_bad;
  logic        [IW-1:0]       in_site, in_col_i;
  logic        [SITES+15:0]   load_x;
  logic        [SITES-1:0]    load_v;
  logic signed [33:0]         cx;
  logic        [CB-1:0]       wdata;
  logic                       we;
  logic        [AW-1:0]       waddr, raddr;
  logic        [CB-1:0]       rdata;
  logic signed [CB-1:0]       rd_s;
  logic                       incl, scan_last;
  logic signed [ACC_W-1:0]    acc_add, dval, new_e;
  logic        [SITES-1:0]    g_new;
  logic                       better;

  logic        [2:0]          op_r;
  logic        [IW-1:0]       site_r, i_r, j_r;
  logic        [AW-1:0]       a_r;
  logic        [SITES-1:0]    spins_r, vec_r, k_r, best_r;
  logic signed [ACC_W-1:0]    acc_r, cur_e_r, best_e_r;
  logic                       incl_r, rdv_r;
  logic signed [31:0]         energy_r;
  logic        [15:0]         sout_r;
  logic                       err_r;

  assign row_x    = SW'(in_row);
  assign col_x    = SW'(in_col);
  assign row_ok   = row_x < SW'(SITES);
  assign col_ok   = col_x < SW'(SITES);
  assign wr_bad   = !row_ok || !col_ok || (in_col > in_row);
  assign in_site  = row_x[IW-1:0];
  assign in_col_i = col_x[IW-1:0];
  assign load_x   = (SITES+16)'(in_spins_in);
  assign load_v   = load_x[SITES-1:0];

  always_comb begin
    cx = 34'(in_coupling);
    if (cx > C_HI) begin
      cx = C_HI;
    end
    if (cx < C_LO) begin
      cx = C_LO;
    end
    wdata = cx[CB-1:0];
  end

  assign we    = cmd.accept && in_op == OP_WRITE && !wr_bad;
  assign waddr = tri_base(in_site) + AW'(in_col_i);

  always_comb begin
    if (op_r == OP_ENERGY) begin
      raddr     = a_r;
      incl      = vec_r[i_r] & vec_r[j_r];
      scan_last = a_r == AW'(DEPTH - 1);
    end else begin
      raddr     = (i_r <= site_r) ? tri_base(site_r) + AW'(i_r)
                                  : tri_base(i_r) + AW'(site_r);
      incl      = vec_r[i_r] | (i_r == site_r);
      scan_last = i_r == IW'(SITES - 1);
    end
  end

  qee_ram #(.WIDTH(CB), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_s    = rdata;
  assign acc_add = (rdv_r && incl_r) ? acc_r + ACC_W'(rd_s) : acc_r;
  assign dval    = vec_r[site_r] ? -acc_r : acc_r;
  assign g_new   = vec_r ^ (SITES'(1) << site_r);
  assign new_e   = cur_e_r + dval;
  assign better  = (new_e < best_e_r) || (new_e == best_e_r && g_new < best_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spins_r <= '0;
      rdv_r   <= 1'b0;
    end else begin
      rdv_r <= cmd.scan;
      if (cmd.accept) begin
        op_r     <= in_op;
        acc_r    <= '0;
        i_r      <= '0;
        j_r      <= '0;
        a_r      <= '0;
        k_r      <= SITES'(1);
        cur_e_r  <= '0;
        best_e_r <= '0;
        best_r   <= '0;
        energy_r <= '0;
        err_r    <= 1'b0;
        sout_r   <= low16(spins_r);
        vec_r    <= (in_op == OP_SEARCH) ? '0 : spins_r;
        site_r   <= (in_op == OP_SEARCH) ? '0 : in_site;
        unique case (in_op)
          OP_WRITE: err_r <= wr_bad;
          OP_LOAD: begin
            spins_r <= load_v;
            sout_r  <= low16(load_v);
          end
          OP_FLIP: begin
            if (row_ok) begin
              spins_r <= spins_r ^ (SITES'(1) << in_site);
              sout_r  <= low16(spins_r ^ (SITES'(1) << in_site));
            end else begin
              err_r <= 1'b1;
            end
          end
          OP_DELTA: err_r <= !row_ok;
          default: ;
        endcase
      end
      if (cmd.scan || cmd.tail) begin
        acc_r  <= acc_add;
        incl_r <= incl;
      end
      if (cmd.scan) begin
        a_r <= a_r + AW'(1);
        if (op_r == OP_ENERGY) begin
          if (j_r == i_r) begin
            i_r <= i_r + IW'(1);
            j_r <= '0;
          end else begin
            j_r <= j_r + IW'(1);
          end
        end else begin
          i_r <= i_r + IW'(1);
        end
      end
      if (cmd.fin) begin
        energy_r <= (op_r == OP_DELTA) ? sat32(dval) : sat32(acc_r);
      end
      if (cmd.supd) begin
        vec_r   <= g_new;
        cur_e_r <= new_e;
        if (better) begin
          best_e_r <= new_e;
          best_r   <= g_new;
        end
        if (&k_r) begin
          energy_r <= better ? sat32(new_e) : sat32(best_e_r);
          sout_r   <= better ? low16(g_new) : low16(best_r);
        end else begin
          k_r    <= k_r + SITES'(1);
          site_r <= ctz(k_r + SITES'(1));
          acc_r  <= '0;
          i_r    <= '0;
          j_r    <= '0;
          a_r    <= '0;
        end
      end
    end
  end

  assign sts.start_scan  = (in_op == OP_DELTA && row_ok) || in_op == OP_ENERGY
                           || in_op == OP_SEARCH;
  assign sts.scan_last   = scan_last;
  assign sts.is_search   = op_r == OP_SEARCH;
  assign sts.search_last = &k_r;

  assign res_energy = energy_r;
  assign res_spins  = sout_r;
  assign res_error  = err_r;

endmodule

// ----- rtl/qubo_energy_engine.sv -----
// Write, load, flip and other codes go straight to the result; delta scans
// SITES couplings; energy scans SITES*(SITES+1)/2, one coupling read a cycle.
// Search walks the Gray code over all 2^SITES - 1 nonzero vectors and
// applies one single-flip delta of SITES reads per step.
// One item at a time; the next is taken once the result has been taken.
// Synchronous active-low reset clears the spins and control; couplings keep.
`timescale 1ns / 1ps
module qubo_energy_engine import qee_pkg::*; #(
  parameter int SITES         = SITES_DEF,
  parameter int COUPLING_BITS = COUPLING_BITS_DEF
) (
  input logic      clk,
  input logic      rst_n,
  qee_in_if.sink   in_ch,
  qee_out_if.source out_ch
);

  cmd_t    cmd;
  status_t sts;

  qee_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  qee_datapath #(.SITES(SITES), .COUPLING_BITS(COUPLING_BITS)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_op       (in_ch.op),
    .in_row      (in_ch.row),
    .in_col      (in_ch.col),
    .in_coupling (in_ch.coupling),
    .in_spins_in (in_ch.spins_in),
    .res_energy  (out_ch.energy),
    .res_spins   (out_ch.spins_out),
    .res_error   (out_ch.error)
  );

endmodule

// ----- tb/qubo_energy_engine_tb.sv -----
// Self-checking testbench for the QUBO energy engine: drives operations over
// the input channel and checks every result against an energy predictor.
// Depends on qee_pkg, qee_in_if, qee_out_if and qubo_energy_engine.
`timescale 1ns / 1ps
module qubo_energy_engine_tb;
  import qee_pkg::*;

  localparam int          NSITES      = SITES_DEF;
  localparam int          STORE_DEPTH = NSITES * (NSITES + 1) / 2;
  localparam int          IDLE_PCT    = 21;
  localparam int          RANDOM_OPS  = 1740;
  localparam longint      CYCLE_LIMIT = 20000000;
  localparam logic [2:0]  OP_SPARE6   = 3'd6;
  localparam logic [2:0]  OP_SPARE7   = 3'd7;

  typedef struct {
    logic signed [31:0] energy;
    logic        [15:0] spins;
    logic               error;
  } result_t;

  class energy_scoreboard;
    logic signed [15:0] couplings [STORE_DEPTH];
    logic        [15:0] spins;
    result_t            expected [$];
    int                 fails;

    function new();
      spins = '0;
      fails = 0;
      foreach (couplings[k]) couplings[k] = '0;
    endfunction

    function longint coupling_at(int r, int c);
      return longint'(couplings[r * (r + 1) / 2 + c]);
    endfunction

    function longint energy_of(logic [15:0] s);
      longint sum;
      sum = 0;
      for (int i = 0; i < NSITES; i++)
        if (s[i])
          for (int j = 0; j <= i; j++)
            if (s[j]) sum += coupling_at(i, j);
      return sum;
    endfunction

    function logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
    endfunction

    function void note_input(logic [2:0] op, logic [3:0] row, logic [3:0] col,
                             logic signed [15:0] coupling, logic [15:0] spins_in);
      result_t r;
      longint  sum, e, best_e;
      logic [15:0] best;
      r.energy = '0;
      r.error  = 1'b0;
      case (op)
        OP_WRITE: begin
          if (col > row) r.error = 1'b1;
          else couplings[row * (row + 1) / 2 + col] = coupling;
        end
        OP_LOAD: spins = spins_in;
        OP_FLIP: spins[row] = ~spins[row];
        OP_DELTA: begin
          sum = 0;
          for (int i = 0; i < NSITES; i++)
            if (spins[i] || i == row)
              sum += (row > i) ? coupling_at(row, i) : coupling_at(i, row);
          if (spins[row]) sum = -sum;
          r.energy = clamp32(sum);
        end
        OP_ENERGY: r.energy = clamp32(energy_of(spins));
        default: ;
      endcase
      r.spins = spins;
      if (op == OP_SEARCH) begin
        best   = '0;
        best_e = 0;
        for (int s = 1; s < (1 << NSITES); s++) begin
          e = energy_of(s[15:0]);
          if (e < best_e) begin
            best_e = e;
            best   = s[15:0];
          end
        end
        r.energy = clamp32(best_e);
        r.spins  = best;
      end
      expected = {expected, r};
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      fails++;
    endtask

    task check(logic signed [31:0] energy, logic [15:0] spins_out, logic error);
      result_t r;
      if (expected.size() == 0) begin
        report("result with no item outstanding");
      end else begin
        r = expected.pop_front();
        if (energy !== r.energy)
          report($sformatf("energy %0d, expected %0d", energy, r.energy));
        if (spins_out !== r.spins)
          report($sformatf("spins %h, expected %h", spins_out, r.spins));
        if (error !== r.error)
          report($sformatf("error %b, expected %b", error, r.error));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic calm;
  longint cycles = 0;
  energy_scoreboard sb;

  qee_in_if  in_ch ();
  qee_out_if out_ch ();

  qubo_energy_engine u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check(out_ch.energy, out_ch.spins_out, out_ch.error);
  end

  task send_op(logic [2:0] op, logic [3:0] row, logic [3:0] col,
               logic signed [15:0] coupling, logic [15:0] spins_in);
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < IDLE_PCT) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.op       <= op;
    in_ch.row      <= row;
    in_ch.col      <= col;
    in_ch.coupling <= coupling;
    in_ch.spins_in <= spins_in;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(op, row, col, coupling, spins_in);
  endtask

  task drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task fill_store();
    logic signed [15:0] v;
    for (int r = 0; r < NSITES; r++)
      for (int c = 0; c <= r; c++) begin
        v = 16'($urandom);
        if (r == 3 && c == 1) v = 16'sh7fff;
        if (r == 9 && c == 4) v = 16'sh8000;
        send_op(OP_WRITE, 4'(r), 4'(c), v, 16'($urandom));
      end
  endtask

  task random_op();
    int          pick;
    logic [3:0]  row, col;
    pick = $urandom_range(99);
    row  = 4'($urandom);
    col  = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(row));
    if (pick < 25)      send_op(OP_WRITE, row, col, 16'($urandom), 16'($urandom));
    else if (pick < 40) send_op(OP_LOAD, row, col, 16'($urandom), 16'($urandom));
    else if (pick < 60) send_op(OP_FLIP, row, col, 16'($urandom), 16'($urandom));
    else if (pick < 80) send_op(OP_DELTA, row, col, 16'($urandom), 16'($urandom));
    else if (pick < 95) send_op(OP_ENERGY, row, col, 16'($urandom), 16'($urandom));
    else if (pick < 98) send_op(OP_SPARE6, row, col, 16'($urandom), 16'($urandom));
    else                send_op(OP_SPARE7, row, col, 16'($urandom), 16'($urandom));
  endtask

  initial begin
    sb = new();
    calm = 1'b0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.op <= OP_LOAD;
    in_ch.row <= '0;
    in_ch.col <= '0;
    in_ch.coupling <= '0;
    in_ch.spins_in <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_op(OP_ENERGY, 4'd0, 4'd0, '0, '0);
    fill_store();
    send_op(OP_WRITE, 4'd2, 4'd5, 16'sh1234, '0);
    send_op(OP_WRITE, 4'd15, 4'd15, 16'sh7fff, '0);
    send_op(OP_WRITE, 4'd0, 4'd0, 16'sh8000, '0);
    send_op(OP_LOAD, '0, '0, '0, 16'hffff);
    send_op(OP_ENERGY, '0, '0, '0, '0);
    send_op(OP_DELTA, 4'd0, '0, '0, '0);
    send_op(OP_DELTA, 4'd15, '0, '0, '0);
    send_op(OP_FLIP, 4'd15, '0, '0, '0);
    send_op(OP_DELTA, 4'd15, '0, '0, '0);
    send_op(OP_FLIP, 4'd0, '0, '0, '0);
    send_op(OP_LOAD, '0, '0, '0, 16'h0000);
    send_op(OP_DELTA, 4'd7, '0, '0, '0);
    send_op(OP_ENERGY, '0, '0, '0, '0);
    send_op(OP_SPARE6, 4'd15, 4'd15, 16'sh7fff, 16'hffff);
    send_op(OP_SPARE7, 4'd0, 4'd0, 16'sh8000, 16'h0000);
    send_op(OP_LOAD, '0, '0, '0, 16'ha5c3);
    send_op(OP_SEARCH, '0, '0, '0, '0);
    send_op(OP_ENERGY, '0, '0, '0, '0);

    for (int n = 0; n < RANDOM_OPS; n++) begin
      calm = (n >= 600 && n < 800);
      if (n == 1000) drain();
      random_op();
    end
    calm = 1'b0;
    send_op(OP_LOAD, '0, '0, '0, 16'($urandom));
    send_op(OP_SEARCH, 4'($urandom), 4'($urandom), 16'($urandom), 16'($urandom));
    send_op(OP_ENERGY, '0, '0, '0, '0);

    drain();
    if (sb.fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
